### hw/rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, register indexes and constants of the PID drive controller.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Soft-start length in control ticks (1 to 255)
  localparam int unsigned RAMP_TICKS = 20;
  localparam int unsigned RAMP_W     = $clog2(RAMP_TICKS + 1);

  // Shared multiplier geometry
  localparam int unsigned MUL_W  = 24;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Ramp division by RAMP_TICKS through a reciprocal
  localparam int unsigned RAMP_X_W = 14 + RAMP_W;
  localparam int unsigned RECIP_SH = MUL_W - 1;
  localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << RECIP_SH) / RAMP_TICKS);

  localparam logic [15:0] RANGE_DEFAULT = 16'd36864;   // 144 inches
  localparam logic [63:0] TERM_CAP      = 64'd1 << 50;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRIVE_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE_MV   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INCH_SCALE     = 3'd6;

  // Input opcodes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integral_gain;
    logic [23:0] deriv_gain;
    logic [15:0] stop_tolerance;
    logic [13:0] min_drive_mv;
    logic [13:0] max_drive_mv;
    logic [15:0] inch_scale;
  } pdc_cfg_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] move_distance;
    logic        [15:0] time_limit_ms;
    logic        [15:0] space_limit;
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic        [31:0] now_ms;
    logic               object_seen;
    logic        [15:0] object_distance;
  } pdc_in_t;

  typedef struct packed {
    logic [13:0] drive_mv;
    logic        drive_reverse;
    logic        drive_on;
    logic        finished;
    logic [31:0] iterations;
  } pdc_out_t;

endpackage

### hw/rtl/pdc_cfg.sv
// ----------------------------------------------------------------------------
// pdc_cfg
// Tuning register file of the PID drive controller, written through a
// plain enable/index/data port.
// ----------------------------------------------------------------------------
module pdc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]       idx_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]      data_i,
  output pdc_pkg::pdc_cfg_t                   cfg_o
);

  pdc_pkg::pdc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= 24'd192000;
      cfg_q.integral_gain  <= 24'd96;
      cfg_q.deriv_gain     <= 24'd5760;
      cfg_q.stop_tolerance <= 16'd102;
      cfg_q.min_drive_mv   <= 14'd2500;
      cfg_q.max_drive_mv   <= 14'd11500;
      cfg_q.inch_scale     <= 16'd20861;
    end else if (we_i) begin
      case (idx_i)
        pdc_pkg::CFG_PROP_GAIN:      cfg_q.prop_gain      <= data_i;
        pdc_pkg::CFG_INTEGRAL_GAIN:  cfg_q.integral_gain  <= data_i;
        pdc_pkg::CFG_DERIV_GAIN:     cfg_q.deriv_gain     <= data_i;
        pdc_pkg::CFG_STOP_TOLERANCE: cfg_q.stop_tolerance <= data_i[15:0];
        pdc_pkg::CFG_MIN_DRIVE_MV:   cfg_q.min_drive_mv   <= data_i[13:0];
        pdc_pkg::CFG_MAX_DRIVE_MV:   cfg_q.max_drive_mv   <= data_i[13:0];
        pdc_pkg::CFG_INCH_SCALE:     cfg_q.inch_scale     <= data_i[15:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/pdc_mul.sv
// ----------------------------------------------------------------------------
// pdc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pdc_mul (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [pdc_pkg::MUL_W-1:0]        a_i,
  input  logic [pdc_pkg::MUL_W-1:0]        b_i,
  output logic [pdc_pkg::PROD_W-1:0]       prod_o
);

  logic [pdc_pkg::PROD_W-1:0] prod_q;

  // Hold the product until the next issue
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= pdc_pkg::PROD_W'(a_i) * pdc_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

### hw/rtl/pid_drive_controller.sv
// ----------------------------------------------------------------------------
// pid_drive_controller
// PID position controller for a two-sided drive with output clamp and
// soft-start ramp, sequenced around one shared 24x24 multiplier.
// ----------------------------------------------------------------------------
// A start item (kind 0) opens a move: the target is the floored mean of the
// two wheel positions plus move_distance scaled by inch_scale (Q16), and the
// timer, obstacle range and PID history are captured or cleared. Each tick
// item (kind 1) in a move stops it (tolerance reached, timeout or obstacle
// too close; finished pulses) or drives: |error| and its sign set direction,
// P + I - D (each term capped at 2^50) is scaled by 2^-16, clamped to the
// min/max drive registers, and ramped up over the first RAMP_TICKS ticks.
// Every item yields exactly one result. The block takes one item at a time:
// it accepts no new item until the result of the last one has been written.
// The shared multiplier sets the sequence: six partial products for the
// three PID terms, and three more for the ramp's scale and divide. A
// finished result waits in the output register while the next item is
// accepted. Write the tuning registers only while no item is in flight.
// ----------------------------------------------------------------------------
module pid_drive_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pdc_pkg::pdc_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pdc_pkg::pdc_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,        // start: |distance| * inch_scale
    ST_TARGET,       // start: commit the new move
    ST_CHECK,        // tick: tolerance, timeout and range checks
    ST_ERROR,        // tick: signed error and magnitude
    ST_PREP,         // tick: integral and derivative operands
    ST_MUL,          // tick: six partial products, three folds
    ST_CLAMP,        // tick: scale and clamp
    ST_RAMP_MUL,     // ramp: (v - min) * ticks
    ST_RAMP_RECIP,   // ramp: times reciprocal of RAMP_TICKS
    ST_RAMP_BACK,    // ramp: quotient estimate times RAMP_TICKS
    ST_RAMP_FIX,     // ramp: correct the quotient by one
    ST_FINISH,       // tick: commit the driving tick
    ST_WRITE         // move the result into the output register
  } state_e;

  // PID term order in the multiply sequence
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;
  localparam logic [2:0] STEP_LAST_ISSUE = 3'd5;
  localparam logic [2:0] STEP_LAST       = 3'd7;

  localparam int unsigned MW = pdc_pkg::MUL_W;
  localparam int unsigned PW = pdc_pkg::PROD_W;
  localparam int unsigned XW = pdc_pkg::RAMP_X_W;

  pdc_pkg::pdc_cfg_t cfg;

  pdc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Control and architectural state
  state_e            state_q;
  logic [2:0]        step_q;
  logic [32:0]       target_q;
  logic [31:0]       start_ms_q;
  logic [15:0]       range_now_q;
  logic [15:0]       range_floor_q;
  logic [15:0]       timeout_q;
  logic [39:0]       accum_q;
  logic [32:0]       last_err_q;
  logic              first_tick_q;
  logic [31:0]       tick_cnt_q;
  logic              moving_q;
  logic              out_valid_q;
  pdc_pkg::pdc_out_t out_q;

  // Working registers of one item
  pdc_pkg::pdc_in_t  in_q;
  pdc_pkg::pdc_out_t res_q;
  logic [31:0]       mean_q;
  logic [32:0]       mag_q;
  logic              rev_q;
  logic [32:0]       dmag_q;
  logic              dneg_q;
  logic [63:0]       acc_q;
  logic [52:0]       sum_q;
  logic [13:0]       v_q;
  logic [XW-1:0]     x_q;
  logic [13:0]       q_q;

  // Shared multiplier
  logic          mul_en;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] prod;

  pdc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Datapath helpers
  logic [32:0]        pos_sum;
  logic [31:0]        mean_now;
  logic [23:0]        dist_mag;
  logic [40:0]        scaled_full;
  logic [32:0]        target_new;
  logic [33:0]        err;
  logic [32:0]        err_mag;
  logic [40:0]        accum_sum;
  logic [39:0]        accum_new;
  logic [33:0]        deriv;
  logic [32:0]        deriv_mag;
  logic [31:0]        elapsed;
  logic               tol_ok;
  logic               time_ok;
  logic               range_ok;
  logic [1:0]         mul_term;
  logic [2:0]         prev_step;
  logic [1:0]         fold_term;
  logic [50:0]        term_sat;
  logic signed [36:0] v_scaled;
  logic signed [36:0] lo_ext;
  logic signed [36:0] hi_ext;
  logic [13:0]        v_clamp;
  logic               ramp_on;
  logic [XW-1:0]      ramp_rem;
  logic [13:0]        q_fixed;
  logic [31:0]        tick_next;
  logic               out_free;

  always_comb begin
    pos_sum  = {in_q.left_position[31], in_q.left_position}
             + {in_q.right_position[31], in_q.right_position};
    mean_now = pos_sum[32:1];

    dist_mag    = in_q.move_distance[23] ? (~in_q.move_distance + 24'd1)
                                         : in_q.move_distance;
    scaled_full = in_q.move_distance[23] ? (~{1'b0, prod[39:0]} + 41'd1)
                                         : {1'b0, prod[39:0]};
    target_new  = {{8{scaled_full[40]}}, scaled_full[40:16]} + {mean_q[31], mean_q};

    err     = {target_q[32], target_q} - {{2{mean_q[31]}}, mean_q};
    err_mag = err[33] ? 33'(~err + 34'd1) : err[32:0];

    accum_sum = {1'b0, accum_q} + {8'd0, mag_q};
    accum_new = accum_sum[40] ? '1 : accum_sum[39:0];
    deriv     = {1'b0, mag_q} - {1'b0, last_err_q};
    deriv_mag = deriv[33] ? 33'(~deriv + 34'd1) : deriv[32:0];

    elapsed  = in_q.now_ms - start_ms_q;
    tol_ok   = first_tick_q || (last_err_q > {17'd0, cfg.stop_tolerance});
    time_ok  = elapsed < {16'd0, timeout_q};
    range_ok = range_now_q >= range_floor_q;

    prev_step = step_q - 3'd1;
    fold_term = step_q[2:1] - 2'd1;
    term_sat  = (acc_q > pdc_pkg::TERM_CAP) ? pdc_pkg::TERM_CAP[50:0] : acc_q[50:0];

    v_scaled = signed'(sum_q[52:16]);
    lo_ext   = signed'({23'd0, cfg.min_drive_mv});
    hi_ext   = signed'({23'd0, cfg.max_drive_mv});
    if (v_scaled < lo_ext) begin
      v_clamp = cfg.min_drive_mv;
    end else if (v_scaled > hi_ext) begin
      v_clamp = cfg.max_drive_mv;
    end else begin
      v_clamp = v_scaled[13:0];
    end
    ramp_on = (tick_cnt_q < 32'(pdc_pkg::RAMP_TICKS)) && (v_clamp > cfg.min_drive_mv);

    ramp_rem = x_q - prod[XW-1:0];
    q_fixed  = (ramp_rem >= XW'(pdc_pkg::RAMP_TICKS)) ? (q_q + 14'd1) : q_q;

    tick_next = (tick_cnt_q == '1) ? tick_cnt_q : (tick_cnt_q + 32'd1);
    out_free  = !out_valid_q || out_ready_i;
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    mul_term = step_q[2:1];
    case (state_q)
      ST_SCALE: begin
        mul_en = 1'b1;
        mul_a  = dist_mag;
        mul_b  = MW'(cfg.inch_scale);
      end
      ST_MUL: begin
        mul_en = (step_q <= STEP_LAST_ISSUE);
        case (mul_term)
          TERM_P: begin
            mul_a = cfg.prop_gain;
            mul_b = step_q[0] ? MW'(mag_q[32:24]) : mag_q[23:0];
          end
          TERM_I: begin
            mul_a = cfg.integral_gain;
            mul_b = step_q[0] ? MW'(accum_q[39:24]) : accum_q[23:0];
          end
          default: begin
            mul_a = cfg.deriv_gain;
            mul_b = step_q[0] ? MW'(dmag_q[32:24]) : dmag_q[23:0];
          end
        endcase
      end
      ST_RAMP_MUL: begin
        mul_en = 1'b1;
        mul_a  = MW'(v_q - cfg.min_drive_mv);
        mul_b  = MW'(tick_cnt_q[pdc_pkg::RAMP_W-1:0]);
      end
      ST_RAMP_RECIP: begin
        mul_en = 1'b1;
        mul_a  = MW'(prod[XW-1:0]);
        mul_b  = pdc_pkg::RECIP;
      end
      ST_RAMP_BACK: begin
        mul_en = 1'b1;
        mul_a  = MW'(prod[pdc_pkg::RECIP_SH +: 14]);
        mul_b  = MW'(pdc_pkg::RAMP_TICKS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      target_q      <= '0;
      start_ms_q    <= '0;
      range_now_q   <= pdc_pkg::RANGE_DEFAULT;
      range_floor_q <= '0;
      timeout_q     <= '0;
      accum_q       <= '0;
      last_err_q    <= '0;
      first_tick_q  <= 1'b1;
      tick_cnt_q    <= '0;
      moving_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
      in_q          <= '0;
      res_q         <= '0;
      mean_q        <= '0;
      mag_q         <= '0;
      rev_q         <= 1'b0;
      dmag_q        <= '0;
      dneg_q        <= 1'b0;
      acc_q         <= '0;
      sum_q         <= '0;
      v_q           <= '0;
      x_q           <= '0;
      q_q           <= '0;
    end else begin
      // drop a taken result; the write step loads the next one itself
      if (out_valid_q && out_ready_i && state_q != ST_WRITE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q <= in_data_i;
            if (in_data_i.kind == pdc_pkg::KIND_START) begin
              res_q   <= '0;
              state_q <= ST_SCALE;
            end else if (moving_q) begin
              res_q   <= '0;
              state_q <= ST_CHECK;
            end else begin
              // idle tick: report the count and change nothing
              res_q   <= {14'd0, 1'b0, 1'b0, 1'b0, tick_cnt_q};
              state_q <= ST_WRITE;
            end
          end
        end
        ST_SCALE: begin
          mean_q  <= mean_now;
          state_q <= ST_TARGET;
        end
        ST_TARGET: begin
          target_q      <= target_new;
          start_ms_q    <= in_q.now_ms;
          timeout_q     <= in_q.time_limit_ms;
          range_floor_q <= in_q.space_limit;
          range_now_q   <= in_q.object_seen ? in_q.object_distance : pdc_pkg::RANGE_DEFAULT;
          accum_q       <= '0;
          last_err_q    <= '0;
          tick_cnt_q    <= '0;
          first_tick_q  <= 1'b1;
          moving_q      <= 1'b1;
          state_q       <= ST_WRITE;
        end
        ST_CHECK: begin
          mean_q <= mean_now;
          if (tol_ok && time_ok && range_ok) begin
            state_q <= ST_ERROR;
          end else begin
            // end the move: stop the drive and report the count
            moving_q         <= 1'b0;
            res_q.finished   <= 1'b1;
            res_q.iterations <= tick_cnt_q;
            state_q          <= ST_WRITE;
          end
        end
        ST_ERROR: begin
          mag_q   <= err_mag;
          rev_q   <= err[33];
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          accum_q <= accum_new;
          dmag_q  <= deriv_mag;
          dneg_q  <= deriv[33];
          sum_q   <= '0;
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          // gather the product issued one step earlier
          if (step_q != 3'd0 && step_q != STEP_LAST) begin
            if (!prev_step[0]) begin
              acc_q <= 64'(prod);
            end else begin
              acc_q <= acc_q + {prod[39:0], 24'd0};
            end
          end
          // fold a finished term into the sum
          if (step_q[0] && step_q != 3'd1) begin
            if (fold_term == TERM_D && !dneg_q) begin
              sum_q <= sum_q - {2'd0, term_sat};
            end else if (fold_term == TERM_D) begin
              sum_q <= sum_q + {2'd0, term_sat};
            end else begin
              sum_q <= sum_q + {2'd0, term_sat};
            end
          end
          step_q <= step_q + 3'd1;
          if (step_q == STEP_LAST) begin
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          v_q     <= v_clamp;
          state_q <= ramp_on ? ST_RAMP_MUL : ST_FINISH;
        end
        ST_RAMP_MUL: begin
          state_q <= ST_RAMP_RECIP;
        end
        ST_RAMP_RECIP: begin
          x_q     <= prod[XW-1:0];
          state_q <= ST_RAMP_BACK;
        end
        ST_RAMP_BACK: begin
          q_q     <= prod[pdc_pkg::RECIP_SH +: 14];
          state_q <= ST_RAMP_FIX;
        end
        ST_RAMP_FIX: begin
          v_q     <= cfg.min_drive_mv + q_fixed;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          res_q.drive_mv      <= v_q;
          res_q.drive_reverse <= rev_q;
          res_q.drive_on      <= 1'b1;
          res_q.finished      <= 1'b0;
          res_q.iterations    <= tick_next;
          last_err_q          <= mag_q;
          first_tick_q        <= 1'b0;
          tick_cnt_q          <= tick_next;
          if (in_q.object_seen) begin
            range_now_q <= in_q.object_distance;
          end
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          // hold until the output register is free
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted item blocks the input until its result is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after an item was accepted");

  // A new result only comes from the write step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_WRITE))
    else $error("result appeared outside the write step");

  // A stopped drive carries no voltage and no direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.drive_on) |->
      (out_data_o.drive_mv == 14'd0 && !out_data_o.drive_reverse))
    else $error("stopped drive with nonzero voltage or reverse");

  // A driving tick has counted itself and does not end the move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.drive_on) |->
      (out_data_o.iterations != 32'd0 && !out_data_o.finished))
    else $error("driving result with zero count or finished set");

endmodule
